// ===== sv/elp_pkg.sv =====
package elp_pkg;

  // Field and datapath widths
  localparam int ENTRY_W = 20;
  localparam int ROW_W   = 60;
  localparam int PT_W    = 16;
  localparam int PROD_W  = 36;
  localparam int L_W     = 38;
  localparam int MAG_W   = 37;
  localparam int HI_W    = 19;
  localparam int LO_W    = 18;
  localparam int SQ_W    = 75;
  localparam int S_W     = 78;
  localparam int ROOT_W  = 39;
  localparam int SREM_W  = 42;
  localparam int NUM_W   = 54;
  localparam int DREM_W  = 40;
  localparam int A_W     = 18;
  localparam int C_W     = 34;
  localparam int FLOOR_W = 32;
  localparam int CFG_W   = 60;
  localparam int IDX_W   = 2;
  localparam int FRAC_SH = 16;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_ROW0  = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROW1  = 2'd1;
  localparam logic [IDX_W-1:0] REG_ROW2  = 2'd2;
  localparam logic [IDX_W-1:0] REG_FLOOR = 2'd3;

  // Result constants
  localparam logic [C_W-1:0]   C_ONE   = 34'd65536;
  localparam logic [C_W-1:0]   C_MAX   = 34'h1_FFFF_FFFF;
  localparam logic [C_W-1:0]   C_MIN   = 34'h2_0000_0000;
  localparam logic [NUM_W-1:0] Q_MAXP  = 54'h1_FFFF_FFFF;
  localparam logic [NUM_W-1:0] Q_MAXN  = 54'h2_0000_0000;

  typedef logic [ROW_W-1:0] row_t;

  // Data carried along the square-root chain
  typedef struct packed {
    logic                    valid;
    logic [S_W-1:0]          s;
    logic [SREM_W-1:0]       rem;
    logic [ROOT_W-1:0]       root;
    logic signed [L_W-1:0]   l0;
    logic signed [L_W-1:0]   l1;
    logic signed [L_W-1:0]   l2;
  } sqrt_t;

  // Data carried along the divider chain, three lanes sharing one divisor
  typedef struct packed {
    logic                        valid;
    logic                        inf;
    logic [ROOT_W-1:0]           d;
    logic [2:0]                  neg;
    logic [2:0][NUM_W-1:0]       n;
    logic [2:0][DREM_W-1:0]      r;
    logic [2:0][NUM_W-1:0]       q;
  } div_t;

  // Matrix entry for output row i and point column j, transposed on request
  function automatic logic signed [ENTRY_W-1:0] coef(input row_t r0, input row_t r1,
                                                      input row_t r2, input logic tr,
                                                      input int i, input int j);
    row_t sel;
    int   rr;
    int   cc;
    rr = tr ? j : i;
    cc = tr ? i : j;
    case (rr)
      0:       sel = r0;
      1:       sel = r1;
      default: sel = r2;
    endcase
    return sel[cc*ENTRY_W +: ENTRY_W];
  endfunction

endpackage

// ===== sv/elp_in_if.sv =====
interface elp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [elp_pkg::PT_W-1:0]       point_x;
  logic signed [elp_pkg::PT_W-1:0]       point_y;
  logic                                  use_transpose;

  modport source (output valid, point_x, point_y, use_transpose, input ready);
  modport sink   (input valid, point_x, point_y, use_transpose, output ready);
endinterface

// ===== sv/elp_out_if.sv =====
interface elp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [elp_pkg::A_W-1:0]        line_a;
  logic signed [elp_pkg::A_W-1:0]        line_b;
  logic signed [elp_pkg::C_W-1:0]        line_c;
  logic                                  at_infinity;

  modport source (output valid, line_a, line_b, line_c, at_infinity, input ready);
  modport sink   (input valid, line_a, line_b, line_c, at_infinity, output ready);
endinterface

// ===== sv/elp_sqrt_cell.sv =====
module elp_sqrt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  elp_pkg::sqrt_t  d_in,
  output elp_pkg::sqrt_t  d_out
);

  logic [elp_pkg::SREM_W-1:0] rs;
  logic [elp_pkg::SREM_W-1:0] trial;
  elp_pkg::sqrt_t             nxt;

  // One root bit: bring down two radicand bits, try root*4+1
  always_comb begin
    rs    = {d_in.rem[elp_pkg::SREM_W-3:0], d_in.s[elp_pkg::S_W-1 -: 2]};
    trial = {1'b0, d_in.root, 2'b01};
    nxt   = d_in;
    nxt.s = {d_in.s[elp_pkg::S_W-3:0], 2'b00};
    if (rs >= trial) begin
      nxt.rem  = rs - trial;
      nxt.root = {d_in.root[elp_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = rs;
      nxt.root = {d_in.root[elp_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out <= nxt;
    end
  end

endmodule

// ===== sv/elp_div_cell.sv =====
module elp_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  elp_pkg::div_t  d_in,
  output elp_pkg::div_t  d_out
);

  logic [elp_pkg::DREM_W-1:0] rs [3];
  logic [elp_pkg::DREM_W-1:0] dd;
  elp_pkg::div_t              nxt;

  // One quotient bit per lane: shift in a numerator bit, subtract if it fits
  always_comb begin
    dd  = {1'b0, d_in.d};
    nxt = d_in;
    for (int k = 0; k < 3; k++) begin
      rs[k]    = {d_in.r[k][elp_pkg::DREM_W-2:0], d_in.n[k][elp_pkg::NUM_W-1]};
      nxt.n[k] = {d_in.n[k][elp_pkg::NUM_W-2:0], 1'b0};
      if (rs[k] >= dd) begin
        nxt.r[k] = rs[k] - dd;
        nxt.q[k] = {d_in.q[k][elp_pkg::NUM_W-2:0], 1'b1};
      end else begin
        nxt.r[k] = rs[k];
        nxt.q[k] = {d_in.q[k][elp_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out <= nxt;
    end
  end

endmodule

// ===== sv/epipolar_line_from_point_unit.sv =====
// Epipolar line unit: one point in, one normalized line out.
// Throughput: one item per cycle unless the output stalls; 6 front stages, 39 square-root
// cells (one root bit each), 1 setup stage, 54 divider cells (one quotient bit each) and
// the output stage.
// The whole pipeline holds only while a result waits in the output register.
// Synchronous reset clears all valid bits and loads matrix 0 and norm floor 1.
module epipolar_line_from_point_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [elp_pkg::IDX_W-1:0]      cfg_index,
  input  logic [elp_pkg::CFG_W-1:0]      cfg_data,
  elp_in_if.sink                         in_ch,
  elp_out_if.source                      out_ch
);

  localparam int NSQ  = elp_pkg::ROOT_W;
  localparam int NDIV = elp_pkg::NUM_W;

  // Configuration registers
  elp_pkg::row_t                  row0;
  elp_pkg::row_t                  row1;
  elp_pkg::row_t                  row2;
  logic [elp_pkg::FLOOR_W-1:0]    norm_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0       <= '0;
      row1       <= '0;
      row2       <= '0;
      norm_floor <= elp_pkg::FLOOR_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        elp_pkg::REG_ROW0:  row0 <= cfg_data;
        elp_pkg::REG_ROW1:  row1 <= cfg_data;
        elp_pkg::REG_ROW2:  row2 <= cfg_data;
        elp_pkg::REG_FLOOR: norm_floor <= cfg_data[elp_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: everything moves unless the output holds an untaken result
  logic en;
  logic ov;
  assign en          = !ov || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: matrix products with x and y
  logic                                  v1;
  logic signed [elp_pkg::PROD_W-1:0]     px  [3];
  logic signed [elp_pkg::PROD_W-1:0]     py  [3];
  logic signed [elp_pkg::ENTRY_W-1:0]    pc  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        px[i] <= elp_pkg::coef(row0, row1, row2, in_ch.use_transpose, i, 0) * in_ch.point_x;
        py[i] <= elp_pkg::coef(row0, row1, row2, in_ch.use_transpose, i, 1) * in_ch.point_y;
        pc[i] <= elp_pkg::coef(row0, row1, row2, in_ch.use_transpose, i, 2);
      end
    end
  end

  // Stage 2: line coefficients l = M p, homogeneous one is 16 in Q.4
  logic                                  v2;
  logic signed [elp_pkg::L_W-1:0]        l2s [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l2s[i] <= elp_pkg::L_W'(px[i]) + elp_pkg::L_W'(py[i])
                + (elp_pkg::L_W'(pc[i]) <<< 4);
      end
    end
  end

  // Stage 3: magnitudes of l0 and l1
  logic                                  v3;
  logic signed [elp_pkg::L_W-1:0]        l3s [3];
  logic [elp_pkg::MAG_W-1:0]             mg3 [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      l3s <= l2s;
      for (int i = 0; i < 2; i++) begin
        mg3[i] <= l2s[i][elp_pkg::L_W-1] ? elp_pkg::MAG_W'(-l2s[i])
                                          : elp_pkg::MAG_W'(l2s[i]);
      end
    end
  end

  // Stage 4: squares split into high and low halves
  logic                                  v4;
  logic signed [elp_pkg::L_W-1:0]        l4s [3];
  logic [2*elp_pkg::HI_W-1:0]            hh  [2];
  logic [elp_pkg::HI_W+elp_pkg::LO_W-1:0] hl [2];
  logic [2*elp_pkg::LO_W-1:0]            ll  [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      l4s <= l3s;
      for (int i = 0; i < 2; i++) begin
        hh[i] <= mg3[i][elp_pkg::MAG_W-1 -: elp_pkg::HI_W]
               * mg3[i][elp_pkg::MAG_W-1 -: elp_pkg::HI_W];
        hl[i] <= mg3[i][elp_pkg::MAG_W-1 -: elp_pkg::HI_W]
               * mg3[i][elp_pkg::LO_W-1:0];
        ll[i] <= mg3[i][elp_pkg::LO_W-1:0] * mg3[i][elp_pkg::LO_W-1:0];
      end
    end
  end

  // Stage 5: assemble each square
  logic                                  v5;
  logic signed [elp_pkg::L_W-1:0]        l5s [3];
  logic [elp_pkg::SQ_W-1:0]              sq  [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      l5s <= l4s;
      for (int i = 0; i < 2; i++) begin
        sq[i] <= (elp_pkg::SQ_W'(hh[i]) << (2*elp_pkg::LO_W))
               + (elp_pkg::SQ_W'(hl[i]) << (elp_pkg::LO_W+1))
               + elp_pkg::SQ_W'(ll[i]);
      end
    end
  end

  // Stage 6: radicand l0^2 + l1^2 feeds the square-root chain
  elp_pkg::sqrt_t sq_ch [NSQ+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_ch[0].valid <= 1'b0;
    end else if (en) begin
      sq_ch[0].valid <= v5;
    end
    if (en) begin
      sq_ch[0].s     <= elp_pkg::S_W'(sq[0]) + elp_pkg::S_W'(sq[1]);
      sq_ch[0].rem   <= '0;
      sq_ch[0].root  <= '0;
      sq_ch[0].l0    <= l5s[0];
      sq_ch[0].l1    <= l5s[1];
      sq_ch[0].l2    <= l5s[2];
    end
  end

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    elp_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (sq_ch[g]),
      .d_out (sq_ch[g+1])
    );
  end

  // Setup stage: degenerate test and rounded numerators for the divider
  elp_pkg::div_t dv_ch [NDIV+1];
  logic signed [elp_pkg::L_W-1:0] lsel [3];
  logic [elp_pkg::MAG_W-1:0]      lmag [3];

  always_comb begin
    lsel[0] = sq_ch[NSQ].l0;
    lsel[1] = sq_ch[NSQ].l1;
    lsel[2] = sq_ch[NSQ].l2;
    for (int k = 0; k < 3; k++) begin
      lmag[k] = lsel[k][elp_pkg::L_W-1] ? elp_pkg::MAG_W'(-lsel[k])
                                         : elp_pkg::MAG_W'(lsel[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ch[0].valid <= 1'b0;
    end else if (en) begin
      dv_ch[0].valid <= sq_ch[NSQ].valid;
    end
    if (en) begin
      dv_ch[0].inf   <= !(sq_ch[NSQ].root > elp_pkg::ROOT_W'(norm_floor));
      dv_ch[0].d     <= sq_ch[NSQ].root;
      for (int k = 0; k < 3; k++) begin
        dv_ch[0].neg[k] <= lsel[k][elp_pkg::L_W-1];
        dv_ch[0].n[k]   <= (elp_pkg::NUM_W'(lmag[k]) << elp_pkg::FRAC_SH)
                         + elp_pkg::NUM_W'(sq_ch[NSQ].root >> 1);
        dv_ch[0].r[k]   <= '0;
        dv_ch[0].q[k]   <= '0;
      end
    end
  end

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    elp_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (dv_ch[g]),
      .d_out (dv_ch[g+1])
    );
  end

  // Output stage: signs, saturation of c and the line at infinity
  elp_pkg::div_t           fin;
  logic [elp_pkg::A_W-1:0] qa;
  logic [elp_pkg::A_W-1:0] qb;
  logic [elp_pkg::C_W-1:0] qc;
  logic [elp_pkg::A_W-1:0] ra;
  logic [elp_pkg::A_W-1:0] rb;
  logic [elp_pkg::C_W-1:0] rc;

  always_comb begin
    fin = dv_ch[NDIV];
    qa  = fin.q[0][elp_pkg::A_W-1:0];
    qb  = fin.q[1][elp_pkg::A_W-1:0];
    qc  = fin.q[2][elp_pkg::C_W-1:0];
    ra  = fin.neg[0] ? -qa : qa;
    rb  = fin.neg[1] ? -qb : qb;
    if (fin.neg[2]) begin
      rc = (fin.q[2] > elp_pkg::Q_MAXN) ? elp_pkg::C_MIN : -qc;
    end else begin
      rc = (fin.q[2] > elp_pkg::Q_MAXP) ? elp_pkg::C_MAX : qc;
    end
    if (fin.inf) begin
      ra = '0;
      rb = '0;
      rc = elp_pkg::C_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= fin.valid;
    end
    if (en) begin
      out_ch.line_a      <= ra;
      out_ch.line_b      <= rb;
      out_ch.line_c      <= rc;
      out_ch.at_infinity <= fin.inf;
    end
  end

  assign out_ch.valid = ov;

endmodule

// ===== sv/elp_checker.sv =====
module elp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [elp_pkg::A_W-1:0]    line_a,
  input logic signed [elp_pkg::A_W-1:0]    line_b,
  input logic signed [elp_pkg::C_W-1:0]    line_c,
  input logic                              at_infinity
);

  // A result not taken stays valid, and its a and c hold
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_a) && $stable(line_c))
    else $error("result changed while stalled");

  // Reset empties the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // The line at infinity is exactly (0, 0, 1.0)
  assert property (@(posedge clk) disable iff (rst)
    out_valid && at_infinity |-> line_a == 0 && line_b == 0 && line_c == 65536)
    else $error("bad line at infinity");

  // Normalized a and b never exceed one
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !at_infinity |->
      line_a >= -65536 && line_a <= 65536 && line_b >= -65536 && line_b <= 65536)
    else $error("normalized coefficient out of range");

endmodule

bind epipolar_line_from_point_unit elp_checker u_elp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .line_a      (out_ch.line_a),
  .line_b      (out_ch.line_b),
  .line_c      (out_ch.line_c),
  .at_infinity (out_ch.at_infinity)
);
